// ===== src/hbdes_pkg.sv =====
// ----------------------------------------------------------------------------
// hbdes_pkg
// Shared widths, codes and reset values of the H-bridge drive / encoder block.
// ----------------------------------------------------------------------------
package hbdes_pkg;

  // Item field widths
  localparam int FUNC_W  = 2;
  localparam int SPEED_W = 16;
  localparam int DUTY_W  = 15;
  localparam int CNT_W   = 16;   // quadrature counter width (8..32)
  localparam int POS_W   = 32;
  localparam int FILT_W  = 24;
  localparam int FRAC_W  = 8;    // fraction bits of the filtered speed (0..16)
  localparam int ALPHA_W = 16;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Item kinds
  localparam logic [FUNC_W-1:0] FUNC_SET_SPEED   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENC_SAMPLE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESET_COUNT = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_COAST       = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SPEED_MAX    = 2'd0;
  localparam logic [1:0] REG_SPEED_MIN    = 2'd1;
  localparam logic [1:0] REG_DEAD_BAND    = 2'd2;
  localparam logic [1:0] REG_FILTER_ALPHA = 2'd3;

  // Register reset values
  localparam logic [SPEED_W-1:0] SPEED_MAX_RST    = 16'h7FFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN_RST    = 16'h8000;
  localparam logic [DUTY_W-1:0]  DEAD_BAND_RST    = 15'd33;
  localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 16'd19661;

  // Bridge pin codes: bit 0 = in1, bit 1 = in2
  localparam logic [1:0] PIN_COAST   = 2'b00;
  localparam logic [1:0] PIN_FORWARD = 2'b01;
  localparam logic [1:0] PIN_REVERSE = 2'b10;
  localparam logic [1:0] PIN_BRAKE   = 2'b11;

endpackage

// ===== src/hbdes_in_if.sv =====
// ----------------------------------------------------------------------------
// hbdes_in_if
// Command channel: item kind, speed command and counter sample.
// ----------------------------------------------------------------------------
interface hbdes_in_if;
  logic                              valid;
  logic                              ready;
  logic [hbdes_pkg::FUNC_W-1:0]      func;
  logic signed [hbdes_pkg::SPEED_W-1:0] speed_cmd;
  logic [hbdes_pkg::CNT_W-1:0]       count_sample;

  modport source (output valid, func, speed_cmd, count_sample, input ready);
  modport sink   (input valid, func, speed_cmd, count_sample, output ready);
endinterface

// ===== src/hbdes_out_if.sv =====
// ----------------------------------------------------------------------------
// hbdes_out_if
// Status channel: bridge pins, duty, applied command, position, speed.
// ----------------------------------------------------------------------------
interface hbdes_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 drive_in1;
  logic                                 drive_in2;
  logic [hbdes_pkg::DUTY_W-1:0]         duty;
  logic signed [hbdes_pkg::SPEED_W-1:0] applied_speed;
  logic signed [hbdes_pkg::POS_W-1:0]   position;
  logic signed [hbdes_pkg::FILT_W-1:0]  filtered_speed;

  modport source (output valid, drive_in1, drive_in2, duty, applied_speed, position,
                  filtered_speed, input ready);
  modport sink   (input valid, drive_in1, drive_in2, duty, applied_speed, position,
                  filtered_speed, output ready);
endinterface

// ===== src/hbridge_drive_encoder_speed.sv =====
// ----------------------------------------------------------------------------
// hbridge_drive_encoder_speed
// Motor channel: clamped H-bridge drive, encoder count extension and a
// first-order low-pass speed filter, one status item per command item.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  cmd      | in  | valid / ready | func, speed_cmd, count_sample
//  status   | out | valid / ready | drive_in1/2, duty, applied_speed,
//           |     |               | position, filtered_speed
//  apb      | in  | psel/penable  | speed_max, speed_min, dead_band, alpha
//
//  Status becomes valid once the input register has taken the item at the
//  accepting edge and the update logic has written the state registers,
//  which drive status; a stalled status delays that write. One item per
//  cycle sustained while status is not stalled; the limit is the filter
//  recurrence (one 17x25 multiply and add per cycle into the speed register).
//  rst is synchronous: it clears the state, the pipeline valids and the
//  registers to their reset values. A stalled status holds everything behind
//  it; cmd keeps being taken while the input register can still move.
//
module hbridge_drive_encoder_speed (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbdes_pkg::ADDR_W-1:0]  paddr,
  input  logic [hbdes_pkg::DATA_W-1:0]  pwdata,
  output logic [hbdes_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  hbdes_in_if.sink                      cmd,
  hbdes_out_if.source                   status
);

  localparam int SPEED_W = hbdes_pkg::SPEED_W;
  localparam int DUTY_W  = hbdes_pkg::DUTY_W;
  localparam int CNT_W   = hbdes_pkg::CNT_W;
  localparam int POS_W   = hbdes_pkg::POS_W;
  localparam int FILT_W  = hbdes_pkg::FILT_W;
  localparam int FRAC_W  = hbdes_pkg::FRAC_W;
  localparam int ALPHA_W = hbdes_pkg::ALPHA_W;
  localparam int DATA_W  = hbdes_pkg::DATA_W;
  localparam int SCL_W   = CNT_W + FRAC_W;            // delta scaled to Q.FRAC
  localparam int DIFF_W  = FILT_W + 1;                // old - scaled
  localparam int PROD_W  = DIFF_W + ALPHA_W + 1;      // alpha * diff
  localparam int ACC_W   = PROD_W + 1;
  localparam int MAG_W   = SPEED_W + 1;

  localparam logic signed [63:0] FILT_MAX = 64'((64'sd1 <<< (FILT_W - 1)) - 64'sd1);
  localparam logic signed [63:0] FILT_MIN = -(64'sd1 <<< (FILT_W - 1));
  localparam logic [MAG_W-1:0]   DUTY_MAX = MAG_W'((1 << DUTY_W) - 1);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (ALPHA_W - 1));

  function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [63:0] v);
    logic signed [FILT_W-1:0] r;
    if (v > FILT_MAX) r = FILT_W'(FILT_MAX);
    else if (v < FILT_MIN) r = FILT_W'(FILT_MIN);
    else r = FILT_W'(v);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] speed_max;
  logic signed [SPEED_W-1:0] speed_min;
  logic [DUTY_W-1:0]         dead_band;
  logic [ALPHA_W-1:0]        filter_alpha;
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_max    <= hbdes_pkg::SPEED_MAX_RST;
      speed_min    <= hbdes_pkg::SPEED_MIN_RST;
      dead_band    <= hbdes_pkg::DEAD_BAND_RST;
      filter_alpha <= hbdes_pkg::FILTER_ALPHA_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hbdes_pkg::REG_SPEED_MAX:    speed_max    <= pwdata[SPEED_W-1:0];
        hbdes_pkg::REG_SPEED_MIN:    speed_min    <= pwdata[SPEED_W-1:0];
        hbdes_pkg::REG_DEAD_BAND:    dead_band    <= pwdata[DUTY_W-1:0];
        hbdes_pkg::REG_FILTER_ALPHA: filter_alpha <= pwdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hbdes_pkg::REG_SPEED_MAX:    prdata = DATA_W'(unsigned'(speed_max));
      hbdes_pkg::REG_SPEED_MIN:    prdata = DATA_W'(unsigned'(speed_min));
      hbdes_pkg::REG_DEAD_BAND:    prdata = DATA_W'(dead_band);
      hbdes_pkg::REG_FILTER_ALPHA: prdata = DATA_W'(filter_alpha);
      default:                     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register and flow control
  // --------------------------------------------------------------------------
  logic                          s1_valid;
  logic [hbdes_pkg::FUNC_W-1:0]  s1_func;
  logic signed [SPEED_W-1:0]     s1_cmd;
  logic [CNT_W-1:0]              s1_sample;
  logic                          out_valid;
  logic                          adv;     // s1 item updates state this cycle

  assign adv       = s1_valid && (!out_valid || status.ready);
  assign cmd.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_func   <= cmd.func;
      s1_cmd    <= cmd.speed_cmd;
      s1_sample <= cmd.count_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // State; also serves as the status result register
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]          last_count;
  logic [POS_W-1:0]          position_acc;
  logic signed [FILT_W-1:0]  speed_filt;
  logic signed [SPEED_W-1:0] clamped_cmd;
  logic [1:0]                pin_state;
  logic [DUTY_W-1:0]         duty_reg;

  // Set speed: clamp (lower clamp wins when crossed), then dead band
  logic signed [SPEED_W-1:0] c_hi;
  logic signed [SPEED_W-1:0] c_clamp;
  logic signed [MAG_W-1:0]   c_ext;
  logic signed [MAG_W-1:0]   db_ext;
  logic signed [MAG_W-1:0]   c_neg;
  logic [1:0]                pin_cmd;
  logic [DUTY_W-1:0]         duty_cmd;

  always_comb begin
    c_hi    = (s1_cmd > speed_max) ? speed_max : s1_cmd;
    c_clamp = (c_hi < speed_min) ? speed_min : c_hi;
    c_ext   = MAG_W'(c_clamp);
    db_ext  = signed'(MAG_W'(dead_band));
    c_neg   = -c_ext;
    if (c_ext > db_ext) begin
      pin_cmd  = hbdes_pkg::PIN_FORWARD;
      duty_cmd = DUTY_W'(c_ext);
    end else if (c_ext < -db_ext) begin
      pin_cmd  = hbdes_pkg::PIN_REVERSE;
      // full-scale negative command saturates the duty
      duty_cmd = (unsigned'(c_neg) > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : DUTY_W'(c_neg);
    end else begin
      pin_cmd  = hbdes_pkg::PIN_BRAKE;
      duty_cmd = '0;
    end
  end

  // Encoder sample: wrapping delta, position and filter
  logic [CNT_W-1:0]          d_raw;
  logic signed [CNT_W-1:0]   delta;
  logic [POS_W-1:0]          delta_ext;
  logic signed [SCL_W-1:0]   scaled_raw;
  logic signed [FILT_W-1:0]  scaled;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_shr;
  logic signed [FILT_W-1:0]  filt_next;

  always_comb begin
    d_raw      = s1_sample - last_count;
    delta      = signed'(d_raw);
    delta_ext  = unsigned'(POS_W'(delta));
    scaled_raw = SCL_W'(delta) <<< FRAC_W;
    scaled     = sat_filt(64'(scaled_raw));
    // alpha*old + (1-alpha)*new == new*2^16 + alpha*(old - new)
    diff       = DIFF_W'(speed_filt) - DIFF_W'(scaled);
    prod       = PROD_W'(signed'({1'b0, filter_alpha})) * PROD_W'(diff);
    acc        = (ACC_W'(scaled) <<< ALPHA_W) + ACC_W'(prod) + ROUND_HALF;
    acc_shr    = acc >>> ALPHA_W;
    filt_next  = sat_filt(64'(acc_shr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count   <= '0;
      position_acc <= '0;
      speed_filt   <= '0;
      clamped_cmd  <= '0;
      pin_state    <= hbdes_pkg::PIN_COAST;
      duty_reg     <= '0;
    end else if (adv) begin
      case (s1_func)
        hbdes_pkg::FUNC_SET_SPEED: begin
          clamped_cmd <= c_clamp;
          pin_state   <= pin_cmd;
          duty_reg    <= duty_cmd;
        end
        hbdes_pkg::FUNC_ENC_SAMPLE: begin
          last_count   <= s1_sample;
          position_acc <= position_acc + delta_ext;
          speed_filt   <= filt_next;
        end
        hbdes_pkg::FUNC_RESET_COUNT: begin
          position_acc <= '0;
        end
        default: begin
          pin_state <= hbdes_pkg::PIN_COAST;
          duty_reg  <= '0;
        end
      endcase
    end
  end

  assign status.valid          = out_valid;
  assign status.drive_in1      = pin_state[0];
  assign status.drive_in2      = pin_state[1];
  assign status.duty           = duty_reg;
  assign status.applied_speed  = clamped_cmd;
  assign status.position       = signed'(position_acc);
  assign status.filtered_speed = speed_filt;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_brake_no_duty: assert property (@(posedge clk) disable iff (rst)
    status.valid && status.drive_in1 && status.drive_in2 |-> status.duty == '0)
    else $error("brake with nonzero duty");

  a_coast_no_duty: assert property (@(posedge clk) disable iff (rst)
    status.valid && !status.drive_in1 && !status.drive_in2 |-> status.duty == '0)
    else $error("coast with nonzero duty");

  a_reset_count: assert property (@(posedge clk) disable iff (rst)
    adv && s1_func == hbdes_pkg::FUNC_RESET_COUNT |=> status.position == '0)
    else $error("position not cleared by reset count");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !status.ready |-> !cmd.ready)
    else $error("input taken while pipeline is full and stalled");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: motor channel drive / encoder / speed filter testbench
// Drives command items with bursty timing and stalls the status channel on
// its own pattern. A local model of the clamp, dead band, counter extension
// and low-pass filter predicts every status item, and the checker compares
// each one field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int FUNC_W  = hbdes_pkg::FUNC_W;
  localparam int SPEED_W = hbdes_pkg::SPEED_W;
  localparam int DUTY_W  = hbdes_pkg::DUTY_W;
  localparam int CNT_W   = hbdes_pkg::CNT_W;
  localparam int POS_W   = hbdes_pkg::POS_W;
  localparam int FILT_W  = hbdes_pkg::FILT_W;
  localparam int FRAC_W  = hbdes_pkg::FRAC_W;
  localparam int ALPHA_W = hbdes_pkg::ALPHA_W;
  localparam int ADDR_W  = hbdes_pkg::ADDR_W;
  localparam int DATA_W  = hbdes_pkg::DATA_W;

  // Status fields expected for one command item
  typedef struct packed {
    logic                      in1;
    logic                      in2;
    logic [DUTY_W-1:0]         duty;
    logic signed [SPEED_W-1:0] applied;
    logic signed [POS_W-1:0]   position;
    logic signed [FILT_W-1:0]  speed;
  } status_t;

  // --------------------------------------------------------------------------
  // Clock, reset, bus and channel drivers (all known from time zero)
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  wire  [DATA_W-1:0] prdata;
  wire               pready;

  logic                      tx_valid = 1'b0;
  logic [FUNC_W-1:0]         tx_func  = hbdes_pkg::FUNC_COAST;
  logic signed [SPEED_W-1:0] tx_speed = '0;
  logic [CNT_W-1:0]          tx_count = '0;
  logic                      rx_ready = 1'b0;

  hbdes_in_if  cmd_if ();
  hbdes_out_if status_if ();

  assign cmd_if.valid        = tx_valid;
  assign cmd_if.func         = tx_func;
  assign cmd_if.speed_cmd    = tx_speed;
  assign cmd_if.count_sample = tx_count;
  assign status_if.ready     = rx_ready;

  hbridge_drive_encoder_speed u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_if),
    .status  (status_if)
  );

  // --------------------------------------------------------------------------
  // Shadow registers and motor state, as they stand after reset
  // --------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] cfg_speed_max = hbdes_pkg::SPEED_MAX_RST;
  logic signed [SPEED_W-1:0] cfg_speed_min = hbdes_pkg::SPEED_MIN_RST;
  logic [DUTY_W-1:0]         cfg_dead_band = hbdes_pkg::DEAD_BAND_RST;
  logic [ALPHA_W-1:0]        cfg_alpha     = hbdes_pkg::FILTER_ALPHA_RST;

  logic [1:0]                drv_pins     = hbdes_pkg::PIN_COAST;
  logic [DUTY_W-1:0]         drv_duty     = '0;
  logic signed [SPEED_W-1:0] drv_applied  = '0;
  logic [CNT_W-1:0]          enc_last     = '0;
  logic [POS_W-1:0]          enc_position = '0;
  logic signed [FILT_W-1:0]  model_speed  = '0;

  status_t status_due[$];   // predicted status items, oldest first
  int      err_count  = 0;
  int      burst_left = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // saturate to the signed 24-bit filter range
  function automatic longint sat_speed(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Advance the motor state by one accepted command and queue its status.
  function automatic void apply_item(input logic [FUNC_W-1:0] f,
                                     input logic signed [SPEED_W-1:0] spd,
                                     input logic [CNT_W-1:0] cnt);
    int               c;
    int               db;
    int               mag;
    logic [CNT_W-1:0] diff;
    longint           delta;
    longint           scaled;
    longint           acc;
    longint           filt;
    status_t          s;
    case (f)
      hbdes_pkg::FUNC_SET_SPEED: begin
        c = spd;
        if (c > cfg_speed_max) c = cfg_speed_max;
        if (c < cfg_speed_min) c = cfg_speed_min;   // lower clamp wins if crossed
        db = int'(cfg_dead_band);
        drv_applied = c[SPEED_W-1:0];
        if (c > db) begin
          drv_pins = hbdes_pkg::PIN_FORWARD;
          mag = c;
        end else if (c < -db) begin
          drv_pins = hbdes_pkg::PIN_REVERSE;
          mag = -c;
        end else begin
          drv_pins = hbdes_pkg::PIN_BRAKE;
          mag = 0;
        end
        // full-scale reverse gives 32768, which pins the duty at its top
        drv_duty = (mag > 32767) ? '1 : mag[DUTY_W-1:0];
      end
      hbdes_pkg::FUNC_ENC_SAMPLE: begin
        diff = cnt - enc_last;                 // wraps modulo the counter width
        delta = longint'($signed(diff));
        enc_last = cnt;
        enc_position = enc_position + delta[POS_W-1:0];
        scaled = sat_speed(delta * (64'sd1 <<< FRAC_W));
        acc = longint'(cfg_alpha) * model_speed
            + longint'(65536 - int'(cfg_alpha)) * scaled + 64'sd32768;
        filt = sat_speed(acc >>> 16);          // floor shift, half rounds up
        model_speed = filt[FILT_W-1:0];
      end
      hbdes_pkg::FUNC_RESET_COUNT: begin
        enc_position = '0;                     // last count and speed kept
      end
      default: begin
        drv_pins = hbdes_pkg::PIN_COAST;
        drv_duty = '0;
      end
    endcase
    s.in1      = drv_pins[0];
    s.in2      = drv_pins[1];
    s.duty     = drv_duty;
    s.applied  = drv_applied;
    s.position = enc_position;
    s.speed    = model_speed;
    status_due.push_back(s);
  endfunction

  // --------------------------------------------------------------------------
  // Bus write: setup, access until pready, then a return to idle.
  // Only called when idle.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      hbdes_pkg::REG_SPEED_MAX:    cfg_speed_max = value[SPEED_W-1:0];
      hbdes_pkg::REG_SPEED_MIN:    cfg_speed_min = value[SPEED_W-1:0];
      hbdes_pkg::REG_DEAD_BAND:    cfg_dead_band = value[DUTY_W-1:0];
      hbdes_pkg::REG_FILTER_ALPHA: cfg_alpha     = value[ALPHA_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Command sender: bursts of random length separated by random gaps.
  // Handshake is read at the falling edge, where nothing is changing.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [FUNC_W-1:0] f,
                           input logic signed [SPEED_W-1:0] spd,
                           input logic [CNT_W-1:0] cnt);
    int gap;
    bit took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tx_valid <= 1'b1;
    tx_func  <= f;
    tx_speed <= spd;
    tx_count <= cnt;
    do begin
      @(negedge clk);
      took = cmd_if.ready;
      if (took) apply_item(f, spd, cnt);
      @(posedge clk);
    end while (!took);
  endtask

  // Drain: stop sending, wait for every predicted status, then let the
  // input and state registers settle before the caller touches the registers.
  task automatic wait_idle();
    tx_valid <= 1'b0;
    burst_left = 0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Status receiver: a stall pattern that may change mode each time rx_tick wraps
  // (always ready, coin flip, one in four, long stalls).
  // --------------------------------------------------------------------------
  logic [5:0] rx_tick = '0;
  int         rx_mode = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick == '1) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       rx_ready <= 1'b1;
      1:       rx_ready <= 1'($urandom_range(0, 1));
      2:       rx_ready <= (rx_tick[1:0] == 2'd0);
      default: rx_ready <= (rx_tick[3:0] >= 4'd10);
    endcase
  end

  // Status checker: compares each accepted item with the oldest prediction.
  always @(negedge clk) begin : status_check
    status_t want;
    if (!rst && status_if.valid === 1'b1 && rx_ready) begin
      if (status_due.size() == 0) begin
        report_mismatch("status item with nothing expected");
      end else begin
        want = status_due.pop_front();
        if (status_if.drive_in1 !== want.in1)
          report_mismatch($sformatf("drive_in1 got %0b want %0b",
                                    status_if.drive_in1, want.in1));
        if (status_if.drive_in2 !== want.in2)
          report_mismatch($sformatf("drive_in2 got %0b want %0b",
                                    status_if.drive_in2, want.in2));
        if (status_if.duty !== want.duty)
          report_mismatch($sformatf("duty got %0d want %0d",
                                    status_if.duty, want.duty));
        if (status_if.applied_speed !== want.applied)
          report_mismatch($sformatf("applied_speed got %0d want %0d",
                                    $signed(status_if.applied_speed),
                                    $signed(want.applied)));
        if (status_if.position !== want.position)
          report_mismatch($sformatf("position got %0d want %0d",
                                    $signed(status_if.position),
                                    $signed(want.position)));
        if (status_if.filtered_speed !== want.speed)
          report_mismatch($sformatf("filtered_speed got %0d want %0d",
                                    $signed(status_if.filtered_speed),
                                    $signed(want.speed)));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset state, then drive commands around the default dead band and at
  // full scale (negative full scale saturates the duty).
  task automatic test_drive_directed();
    send_item(hbdes_pkg::FUNC_COAST, 16'sd0, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sh7FFF, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sh8000, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sd0, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sd33, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sd34, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, -16'sd33, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, -16'sd34, 16'h0000);
    send_item(hbdes_pkg::FUNC_COAST, 16'sh7FFF, 16'hFFFF);
  endtask

  // Largest forward step, the half-range step that reads as negative,
  // counter wrap both ways and a count reset that keeps the last sample.
  task automatic test_encoder_directed();
    send_item(hbdes_pkg::FUNC_ENC_SAMPLE, 16'sd0, enc_last + 16'h7FFF);
    send_item(hbdes_pkg::FUNC_ENC_SAMPLE, 16'sd0, enc_last + 16'h8000);
    send_item(hbdes_pkg::FUNC_ENC_SAMPLE, 16'sd0, 16'h0000);
    send_item(hbdes_pkg::FUNC_ENC_SAMPLE, 16'sd0, 16'hFFFF);
    send_item(hbdes_pkg::FUNC_RESET_COUNT, 16'sd0, 16'h0000);
    send_item(hbdes_pkg::FUNC_ENC_SAMPLE, 16'sd0, 16'h0010);
  endtask

  // Crossed clamps, dead band at both ends, filter weight at both ends.
  task automatic test_register_extremes();
    wait_idle();
    write_reg(hbdes_pkg::REG_SPEED_MAX, 32'hFFFF_FC18);    // -1000
    write_reg(hbdes_pkg::REG_SPEED_MIN, 32'h0000_03E8);    // +1000, above the max
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sd0, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sh8000, 16'h0000);
    wait_idle();
    write_reg(hbdes_pkg::REG_SPEED_MAX, 32'h0000_7FFF);
    write_reg(hbdes_pkg::REG_SPEED_MIN, 32'h0000_8000);
    write_reg(hbdes_pkg::REG_DEAD_BAND, 32'h0000_0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sd1, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sd0, 16'h0000);
    send_item(hbdes_pkg::FUNC_SET_SPEED, -16'sd1, 16'h0000);
    wait_idle();
    write_reg(hbdes_pkg::REG_DEAD_BAND, 32'h0000_7FFF);
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sh7FFF, 16'h0000);   // brakes
    send_item(hbdes_pkg::FUNC_SET_SPEED, 16'sh8000, 16'h0000);   // still reverses
    wait_idle();
    write_reg(hbdes_pkg::REG_FILTER_ALPHA, 32'h0000_0000);       // filter follows input
    send_item(hbdes_pkg::FUNC_ENC_SAMPLE, 16'sd0, enc_last + 16'h0064);
    wait_idle();
    write_reg(hbdes_pkg::REG_FILTER_ALPHA, 32'h0000_FFFF);       // filter nearly frozen
    send_item(hbdes_pkg::FUNC_ENC_SAMPLE, 16'sd0, enc_last - 16'h0064);
    wait_idle();
    write_reg(hbdes_pkg::REG_DEAD_BAND, {17'd0, hbdes_pkg::DEAD_BAND_RST});
    write_reg(hbdes_pkg::REG_FILTER_ALPHA, {16'd0, hbdes_pkg::FILTER_ALPHA_RST});
  endtask

  // New register set for one random phase; upper bus bits are junk.
  task automatic randomize_registers();
    int           v;
    logic [15:0]  hi_max;
    logic [15:0]  lo_min;
    logic [15:0]  db;
    logic [15:0]  al;
    case ($urandom_range(0, 3))
      0: begin
        hi_max = 16'h7FFF;
        lo_min = 16'h8000;
      end
      1: begin
        v = $urandom_range(1000, 32767);
        hi_max = v[15:0];
        lo_min = 16'(-v);
      end
      2: begin   // crossed clamps
        lo_min = 16'($urandom_range(0, 20000));
        hi_max = lo_min - 16'($urandom_range(1, 20000));
      end
      default: begin
        hi_max = 16'($urandom);
        lo_min = 16'($urandom);
      end
    endcase
    case ($urandom_range(0, 3))
      0:       db = 16'h0000;
      1:       db = 16'h7FFF;
      default: db = 16'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 3))
      0:       al = 16'h0000;
      1:       al = 16'hFFFF;
      default: al = 16'($urandom);
    endcase
    write_reg(hbdes_pkg::REG_SPEED_MAX,    {16'($urandom), hi_max});
    write_reg(hbdes_pkg::REG_SPEED_MIN,    {16'($urandom), lo_min});
    write_reg(hbdes_pkg::REG_DEAD_BAND,    {16'($urandom), 1'($urandom), db[14:0]});
    write_reg(hbdes_pkg::REG_FILTER_ALPHA, {16'($urandom), al});
  endtask

  // Random phases: mostly plausible motion (small counter steps, commands
  // near the dead band edges) with full-range jumps and junk mixed in.
  task automatic test_random_traffic();
    int                        r;
    int                        v;
    logic signed [SPEED_W-1:0] spd;
    logic [CNT_W-1:0]          smp;
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      randomize_registers();
      for (int n = 0; n < 150; n++) begin
        r   = $urandom_range(0, 99);
        spd = 16'($urandom);
        smp = 16'($urandom);
        if (r < 40) begin
          v = $urandom_range(0, 9);
          if (v == 0) spd = 16'sh7FFF;
          else if (v == 1) spd = 16'sh8000;
          else if (v < 5) begin
            v = int'(cfg_dead_band) + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) == 1) v = -v;
            spd = v[SPEED_W-1:0];
          end
          send_item(hbdes_pkg::FUNC_SET_SPEED, spd, smp);
        end else if (r < 80) begin
          if ($urandom_range(0, 4) != 0)
            smp = enc_last + CNT_W'(int'($urandom_range(0, 400)) - 200);
          send_item(hbdes_pkg::FUNC_ENC_SAMPLE, spd, smp);
        end else if (r < 90) begin
          send_item(hbdes_pkg::FUNC_RESET_COUNT, spd, smp);
        end else begin
          send_item(hbdes_pkg::FUNC_COAST, spd, smp);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_drive_directed();
    test_encoder_directed();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("PASS hbridge_drive_encoder_speed");
    end else begin
      $display("FAIL hbridge_drive_encoder_speed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("FAIL hbridge_drive_encoder_speed");
    $finish;
  end

endmodule

// ===== hbridge_drive_encoder_speed.f =====
src/hbdes_pkg.sv
src/hbdes_in_if.sv
src/hbdes_out_if.sv
src/hbridge_drive_encoder_speed.sv
test/tb.sv
